>>> sv/kfsa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, a state type and a helper function of the k-th free slot allocator.
package kfsa_pkg;

	localparam int SLOTS_DEFAULT = 1024;
	localparam int FIELD_W = 11;
	localparam logic [FIELD_W-1:0] ACTIVE_RESET = 11'd1024;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	function automatic int addr_w(input int bits);
		return (bits < 1) ? 1 : bits;
	endfunction

endpackage

>>> sv/kfsa_level_cell.sv
`timescale 1ns / 1ps
// One tree level: child counts of that level's nodes and the step down to the next level.
module kfsa_level_cell import kfsa_pkg::*; #(
	parameter int LEVEL = 0,
	parameter int CW = 11,
	parameter int RW = 10,
	parameter int CLR_W = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr_en,
	input  logic [CLR_W-1:0] clr_addr,
	input  logic          up_valid,
	input  logic [RW-1:0] up_row,
	input  logic [CW-1:0] up_lo,
	input  logic [CW-1:0] up_hi,
	input  logic [CW-1:0] up_k,
	output logic          dn_valid,
	output logic [RW-1:0] dn_row,
	output logic [CW-1:0] dn_lo,
	output logic [CW-1:0] dn_hi,
	output logic [CW-1:0] dn_k
);

	localparam int AW = addr_w(LEVEL);
	localparam int ROWS = 1 << AW;

	logic [2*CW-1:0] mem_q [ROWS];
	logic [2*CW-1:0] rd_q;

	logic          valid_s1;
	logic          act_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] lo_s1;
	logic [CW-1:0] hi_s1;
	logic [CW-1:0] k_s1;
	logic [CW-1:0] mid_s1;
	logic [CW-1:0] wid_s1;

	logic          dn_valid_q;
	logic [RW-1:0] dn_row_q;
	logic [CW-1:0] dn_lo_q;
	logic [CW-1:0] dn_hi_q;
	logic [CW-1:0] dn_k_q;

	logic [CW:0]   sum_a;
	logic [CW-1:0] mid_a;
	logic [CW-1:0] wid_a;
	logic          act_a;
	logic [CW-1:0] left_cnt;
	logic [CW-1:0] right_cnt;
	logic [CW-1:0] left_free;
	logic          go_left;

	// Split the range combinationally, while the row is read.
	always_comb begin
		sum_a = {1'b0, up_lo} + {1'b0, up_hi};
		mid_a = sum_a[CW:1];
		wid_a = mid_a - up_lo + CW'(1);
		act_a = up_lo < up_hi;
	end

	// Choose a child from the registered row and update its count.
	always_comb begin
		left_cnt = rd_q[2*CW-1:CW];
		right_cnt = rd_q[CW-1:0];
		left_free = (wid_s1 >= left_cnt) ? wid_s1 - left_cnt : '0;
		go_left = k_s1 <= left_free;
	end

	always_ff @(posedge clk) begin
		if (up_valid) begin
			rd_q <= mem_q[up_row[AW-1:0]];
		end
		if (clr_en) begin
			mem_q[clr_addr[AW-1:0]] <= '0;
		end else if (valid_s1 && act_s1) begin
			mem_q[row_s1[AW-1:0]] <= go_left ? {left_cnt + CW'(1), right_cnt}
				: {left_cnt, right_cnt + CW'(1)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			dn_valid_q <= 1'b0;
		end else begin
			valid_s1 <= up_valid;
			dn_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid) begin
			act_s1 <= act_a;
			row_s1 <= up_row;
			lo_s1 <= up_lo;
			hi_s1 <= up_hi;
			k_s1 <= up_k;
			mid_s1 <= mid_a;
			wid_s1 <= wid_a;
		end
		if (valid_s1) begin
			if (!act_s1) begin
				dn_row_q <= row_s1;
				dn_lo_q <= lo_s1;
				dn_hi_q <= hi_s1;
				dn_k_q <= k_s1;
			end else if (go_left) begin
				dn_row_q <= row_s1 << 1;
				dn_lo_q <= lo_s1;
				dn_hi_q <= mid_s1;
				dn_k_q <= k_s1;
			end else begin
				dn_row_q <= (row_s1 << 1) | RW'(1);
				dn_lo_q <= mid_s1 + CW'(1);
				dn_hi_q <= hi_s1;
				dn_k_q <= k_s1 - left_free;
			end
		end
	end

	assign dn_valid = dn_valid_q;
	assign dn_row = dn_row_q;
	assign dn_lo = dn_lo_q;
	assign dn_hi = dn_hi_q;
	assign dn_k = dn_k_q;

endmodule

>>> sv/kth_free_slot_allocator.sv
`timescale 1ns / 1ps
// Top level of the k-th free slot allocator: root count, control and a chain of level cells.
// Each level cell holds two registers: it reads that level's count memory, then chooses a child
// and writes the updated count back.
// A new request can be taken the cycle after the previous response enters the output register,
// so only one request is in flight at a time; a rejected request skips the level chain.
// After reset and after every active_slots write, a clearing sweep zeroes the counts
// while req_stall stays high.
module kth_free_slot_allocator import kfsa_pkg::*; #(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [FIELD_W-1:0] rank,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [FIELD_W-1:0] slot,
	output logic               failed,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FIELD_W-1:0] active_slots
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam int D = $clog2(SLOTS);
	localparam int WW = (CW > FIELD_W) ? CW : FIELD_W;
	localparam int CLR_W = addr_w(D - 1);
	localparam logic [CLR_W-1:0] CLR_LAST = '1;

	state_t state_q;
	logic [CLR_W-1:0]   clr_q;
	logic [FIELD_W-1:0] active_q;
	logic [CW-1:0]      root_q;
	logic               start_q;
	logic [CW-1:0]      hi0_q;
	logic [CW-1:0]      k0_q;
	logic [FIELD_W-1:0] res_slot_q;
	logic               res_fail_q;
	logic               rsp_valid_q;
	logic [FIELD_W-1:0] slot_q;
	logic               failed_q;

	logic          tv   [D+1];
	logic [D-1:0]  trow [D+1];
	logic [CW-1:0] tlo  [D+1];
	logic [CW-1:0] thi  [D+1];
	logic [CW-1:0] tk   [D+1];

	logic [WW-1:0] active_w;
	logic [WW-1:0] n_eff;
	logic [WW-1:0] free_w;
	logic [WW-1:0] rank_w;
	logic          reject;
	logic          accept;
	logic          rsp_load;
	logic          clr_en;

	always_comb begin
		active_w = WW'(active_q);
		n_eff = (active_w > WW'(SLOTS)) ? WW'(SLOTS) : active_w;
		free_w = n_eff - WW'(root_q);
		rank_w = WW'(rank);
		reject = (n_eff == '0) || (rank_w == '0) || (rank_w > free_w);
	end

	assign req_stall = (state_q != ST_IDLE) || cfg_valid;
	assign accept = req_valid && !req_stall;
	assign rsp_load = (state_q == ST_HOLD) && (!rsp_valid_q || !rsp_stall);
	assign clr_en = (state_q == ST_CLEAR);
	assign cfg_ready = (state_q == ST_IDLE) || (state_q == ST_CLEAR);

	assign tv[0] = start_q;
	assign trow[0] = '0;
	assign tlo[0] = CW'(1);
	assign thi[0] = hi0_q;
	assign tk[0] = k0_q;

	for (genvar g = 0; g < D; g++) begin : g_level
		kfsa_level_cell #(
			.LEVEL(g),
			.CW(CW),
			.RW(D),
			.CLR_W(CLR_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.clr_en(clr_en),
			.clr_addr(clr_q),
			.up_valid(tv[g]),
			.up_row(trow[g]),
			.up_lo(tlo[g]),
			.up_hi(thi[g]),
			.up_k(tk[g]),
			.dn_valid(tv[g+1]),
			.dn_row(trow[g+1]),
			.dn_lo(tlo[g+1]),
			.dn_hi(thi[g+1]),
			.dn_k(tk[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			active_q <= ACTIVE_RESET;
			root_q <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= accept && !reject && !cfg_valid;
			if (cfg_valid && cfg_ready) begin
				active_q <= active_slots;
				root_q <= '0;
				clr_q <= '0;
				state_q <= ST_CLEAR;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + CLR_W'(1);
						if (clr_q == CLR_LAST) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							if (reject) begin
								state_q <= ST_HOLD;
							end else begin
								root_q <= root_q + CW'(1);
								state_q <= ST_RUN;
							end
						end
					end
					ST_RUN: begin
						if (tv[D]) begin
							state_q <= ST_HOLD;
						end
					end
					ST_HOLD: begin
						if (rsp_load) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_CLEAR;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			k0_q <= CW'(rank);
			hi0_q <= CW'(n_eff);
			if (reject) begin
				res_slot_q <= '0;
				res_fail_q <= 1'b1;
			end
		end
		if ((state_q == ST_RUN) && tv[D]) begin
			res_slot_q <= FIELD_W'(tlo[D]);
			res_fail_q <= 1'b0;
		end
		if (rsp_load) begin
			slot_q <= res_slot_q;
			failed_q <= res_fail_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign slot = slot_q;
	assign failed = failed_q;

	a_root_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(root_q) <= n_eff)
		else $error("Taken count exceeds the number of active slots.");

	a_chain_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tv[D] |-> (state_q == ST_RUN))
		else $error("Level chain finished while no request was in flight.");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && reject && !cfg_valid) |=> ((state_q == ST_HOLD) && res_fail_q))
		else $error("Rejected request did not produce a failure result.");

	a_success_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !failed) |-> (slot != '0))
		else $error("Successful response carries slot zero.");

endmodule

>>> verif/kth_free_slot_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the k-th free slot allocator with random ranks and slot counts.
module kth_free_slot_allocator_test;
	import kfsa_pkg::*;

	localparam int SLOT_COUNT = SLOTS_DEFAULT;
	localparam int STIM_ITEMS = 1600;
	localparam int CALM_FROM = 1400;
	localparam int QUIET_LIMIT = 4000;
	localparam int FIELD_MAX = (1 << FIELD_W) - 1;

	typedef struct packed {
		logic [FIELD_W-1:0] slot_no;
		logic               refused;
	} grant_t;

	class slot_allocation_tracker;
		bit          taken [1:SLOT_COUNT];
		int unsigned slot_count;
		grant_t      pending_grants[$];
		int          errors;

		function new();
			errors = 0;
			set_slot_count(ACTIVE_RESET);
		endfunction

		function void set_slot_count(logic [FIELD_W-1:0] value);
			slot_count = (value > SLOT_COUNT) ? SLOT_COUNT : value;
			foreach (taken[i]) taken[i] = 1'b0;
		endfunction

		function int free_slots();
			int n;
			n = 0;
			for (int i = 1; i <= slot_count; i++) begin
				if (!taken[i]) n++;
			end
			return n;
		endfunction

		// The granted slot is the k-th free one in ascending order; a refused item leaves
		// every slot as it was.
		function void record_rank(logic [FIELD_W-1:0] rank_in);
			grant_t g;
			int     left;
			g.slot_no = '0;
			g.refused = 1'b1;
			if (rank_in != 0 && rank_in <= free_slots()) begin
				left = int'(rank_in);
				for (int i = 1; i <= slot_count; i++) begin
					if (!taken[i]) begin
						left--;
						if (left == 0) begin
							taken[i] = 1'b1;
							g.slot_no = FIELD_W'(i);
							g.refused = 1'b0;
							break;
						end
					end
				end
			end
			pending_grants.push_back(g);
		endfunction

		function void check_grant(logic [FIELD_W-1:0] slot_out, logic failed_out);
			grant_t want;
			if (pending_grants.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, slot %0d failed %0d", $time, slot_out,
					failed_out);
				return;
			end
			want = pending_grants.pop_front();
			if (slot_out !== want.slot_no) begin
				errors++;
				$display("%0t: slot expected %0d actual %0d", $time, want.slot_no, slot_out);
			end
			if (failed_out !== want.refused) begin
				errors++;
				$display("%0t: failed expected %0d actual %0d", $time, want.refused,
					failed_out);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [FIELD_W-1:0] rank = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [FIELD_W-1:0] slot;
	logic               failed;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [FIELD_W-1:0] active_slots = '0;

	slot_allocation_tracker tracker;
	bit idle_on = 1'b1;
	int items_sent = 0;
	int quiet_cycles = 0;
	int stall_left = 0;

	kth_free_slot_allocator #(
		.SLOTS(SLOT_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rank(rank),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.slot(slot),
		.failed(failed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.active_slots(active_slots)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) tracker.check_grant(slot, failed);
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = int'($urandom_range(1, 19)) - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	task automatic wait_drained();
		while (tracker.pending_grants.size() != 0) @(posedge clk);
	endtask

	task automatic send_rank(input int k);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_valid <= 1'b1;
		rank <= FIELD_W'(k);
		do @(posedge clk); while (req_stall);
		tracker.record_rank(FIELD_W'(k));
		items_sent++;
	endtask

	task automatic write_count(input int value);
		req_valid <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		active_slots <= FIELD_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_slot_count(FIELD_W'(value));
	endtask

	function automatic int pick_count();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return SLOT_COUNT;
			4: return FIELD_MAX;
			5: return int'($urandom_range(3, 64));
			6: return int'($urandom_range(65, FIELD_MAX));
			default: return int'($urandom_range(3, 40));
		endcase
	endfunction

	// Mostly ranks that can be granted, so the store fills up; the rest probe refusals or are random.
	function automatic int pick_rank();
		int free_now;
		int r;
		free_now = tracker.free_slots();
		r = int'($urandom_range(0, 19));
		if (free_now > 0 && r < 15) return int'($urandom_range(1, free_now));
		if (r < 16) return 0;
		if (r < 18) return (free_now < FIELD_MAX) ? free_now + 1 : FIELD_MAX;
		return int'($urandom_range(0, FIELD_MAX));
	endfunction

	initial begin
		int  phase_len;
		bit  paused;
		paused = 1'b0;
		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_rank(1);
		send_rank(1);
		send_rank(SLOT_COUNT);
		send_rank(SLOT_COUNT - 2);
		send_rank(0);
		send_rank(FIELD_MAX);
		send_rank(SLOT_COUNT - 3);
		send_rank(3);
		write_count(0);
		send_rank(1);
		send_rank(0);
		write_count(1);
		send_rank(1);
		send_rank(1);
		write_count(FIELD_MAX);
		send_rank(SLOT_COUNT);
		send_rank(SLOT_COUNT - 1);
		write_count(SLOT_COUNT + 1);
		send_rank(SLOT_COUNT);
		write_count(2);
		send_rank(2);
		send_rank(1);
		send_rank(1);

		while (items_sent < STIM_ITEMS) begin
			write_count(pick_count());
			phase_len = (tracker.slot_count > 64) ? int'($urandom_range(150, 250))
				: int'(tracker.slot_count) + int'($urandom_range(5, 30));
			for (int j = 0; j < phase_len; j++) begin
				if (items_sent >= STIM_ITEMS) break;
				if (items_sent >= CALM_FROM) idle_on = 1'b0;
				if (!paused && j == phase_len / 2) begin
					req_valid <= 1'b0;
					wait_drained();
					paused = 1'b1;
				end
				send_rank(pick_rank());
			end
		end

		req_valid <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_grants.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/kfsa_pkg.sv
sv/kfsa_level_cell.sv
sv/kth_free_slot_allocator.sv
verif/kth_free_slot_allocator_test.sv
